// ===== rtl/dcac_pkg.sv =====
// Shared types and constants for the dual channel arming controller.
package dcac_pkg;

    localparam int LVL_W       = 7;
    localparam int LED_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 48;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LVL_W-1:0] SWITCH_MIDPOINT_RST = 7'd50;
    localparam logic [LVL_W-1:0] THROTTLE_MAX_RST    = 7'd2;
    localparam logic [LVL_W-1:0] CENTRE_LOW_RST      = 7'd45;
    localparam logic [LVL_W-1:0] CENTRE_HIGH_RST     = 7'd55;

    localparam logic [LED_W-1:0] LED_OFF     = 4'b0000;
    localparam logic [LED_W-1:0] LED_DRIVE   = 4'b0011;
    localparam logic [LED_W-1:0] LED_FULL    = 4'b1111;
    localparam logic [LED_W-1:0] RIPPLE_RST  = 4'b0001;

    typedef enum logic [1:0] {
        CMD_ARM      = 2'd0,
        CMD_FAILSAFE = 2'd1,
        CMD_LED      = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_DRIVE    = 2'd1,
        MODE_WEAPON   = 2'd2,
        MODE_FULL     = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWITCH_MIDPOINT = 2'd0,
        CFG_THROTTLE_MAX    = 2'd1,
        CFG_CENTRE_LOW      = 2'd2,
        CFG_CENTRE_HIGH     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_cmd cmd;
        logic wsw;
        logic dsw;
        logic warm;
        logic wstall;
        logic dstall;
    } t_cls;

endpackage

// ===== rtl/dcac_front.sv =====
// Front end: configuration registers and item classification.
module dcac_front
    import dcac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [LVL_W-1:0]      i_cfg_wdata,
    input  logic [IN_DATA_W-1:0]  i_data,
    input  logic [IN_USER_W-1:0]  i_user,
    output t_cls                  o_cls
);

    logic [LVL_W-1:0] r_switch_mid;
    logic [LVL_W-1:0] r_throttle_max;
    logic [LVL_W-1:0] r_centre_low;
    logic [LVL_W-1:0] r_centre_high;

    logic [LVL_W-1:0] w_wsw_lvl;
    logic [LVL_W-1:0] w_dsw_lvl;
    logic [LVL_W-1:0] w_throttle;
    logic [LVL_W-1:0] w_elev;
    logic [LVL_W-1:0] w_rudder;
    logic [LVL_W-1:0] w_aileron;
    logic             w_centred;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch_mid   <= SWITCH_MIDPOINT_RST;
            r_throttle_max <= THROTTLE_MAX_RST;
            r_centre_low   <= CENTRE_LOW_RST;
            r_centre_high  <= CENTRE_HIGH_RST;
        end else if (i_cfg_wen) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SWITCH_MIDPOINT: r_switch_mid   <= i_cfg_wdata;
                CFG_THROTTLE_MAX:    r_throttle_max <= i_cfg_wdata;
                CFG_CENTRE_LOW:      r_centre_low   <= i_cfg_wdata;
                CFG_CENTRE_HIGH:     r_centre_high  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_wsw_lvl  = i_data[LVL_W-1:0];
    assign w_dsw_lvl  = i_data[2*LVL_W-1:LVL_W];
    assign w_throttle = i_data[3*LVL_W-1:2*LVL_W];
    assign w_elev     = i_data[4*LVL_W-1:3*LVL_W];
    assign w_rudder   = i_data[5*LVL_W-1:4*LVL_W];
    assign w_aileron  = i_data[6*LVL_W-1:5*LVL_W];

    assign w_centred = (w_elev >= r_centre_low) && (w_elev <= r_centre_high) &&
                       (w_rudder >= r_centre_low) && (w_rudder <= r_centre_high) &&
                       (w_aileron >= r_centre_low) && (w_aileron <= r_centre_high);

    always_comb begin
        o_cls.cmd    = t_cmd'(i_user);
        o_cls.wsw    = w_wsw_lvl > r_switch_mid;
        o_cls.dsw    = w_dsw_lvl > r_switch_mid;
        o_cls.wstall = i_data[6*LVL_W];
        o_cls.dstall = i_data[6*LVL_W+1];
        o_cls.warm   = o_cls.wsw && !o_cls.wstall &&
                       (w_throttle <= r_throttle_max) && w_centred;
    end

endmodule

// ===== rtl/dcac_queue.sv =====
// Short queue of classified items between front and back.
module dcac_queue
    import dcac_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_cls,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cls o_cls
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cls   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push without pop did not grow queue");

endmodule

// ===== rtl/dcac_back.sv =====
// Back end: arming state machine, LED state and result register.
module dcac_back
    import dcac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_cls             i_cls,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output t_mode            o_mode,
    output logic [LED_W-1:0] o_led
);

    t_mode            r_mode,   n_mode;
    t_mode            r_shown,  n_shown;
    logic [LED_W-1:0] r_led,    n_led;
    logic [LED_W-1:0] r_ripple, n_ripple;
    logic             r_first,  n_first;
    logic             r_valid,  n_valid;

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_mode  = r_mode;
    assign o_led   = r_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_DISARMED;
            r_shown  <= MODE_DISARMED;
            r_led    <= LED_OFF;
            r_ripple <= RIPPLE_RST;
            r_first  <= 1'b1;
            r_valid  <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_shown  <= n_shown;
            r_led    <= n_led;
            r_ripple <= n_ripple;
            r_first  <= n_first;
            r_valid  <= n_valid;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_shown  = r_shown;
        n_led    = r_led;
        n_ripple = r_ripple;
        n_first  = r_first;
        n_valid  = r_valid && !i_ready;
        if (o_pop) begin
            n_valid = 1'b1;
            case (i_cls.cmd)
                CMD_ARM: begin
                    case (r_mode)
                        MODE_FULL: begin
                            if (!i_cls.dsw && !i_cls.wsw)     n_mode = MODE_DISARMED;
                            else if (i_cls.dsw && !i_cls.wsw) n_mode = MODE_DRIVE;
                            else if (!i_cls.dsw && i_cls.wsw) n_mode = MODE_WEAPON;
                        end
                        MODE_DRIVE: begin
                            if (!i_cls.dsw)       n_mode = MODE_DISARMED;
                            else if (i_cls.warm)  n_mode = MODE_FULL;
                        end
                        MODE_WEAPON: begin
                            if (!i_cls.wsw)      n_mode = MODE_DISARMED;
                            else if (i_cls.dsw)  n_mode = MODE_FULL;
                        end
                        default: begin
                            if (i_cls.dsw && i_cls.warm) n_mode = MODE_FULL;
                            else if (i_cls.dsw)          n_mode = MODE_DRIVE;
                            else if (i_cls.warm)         n_mode = MODE_WEAPON;
                        end
                    endcase
                end
                CMD_FAILSAFE: begin
                    case (r_mode)
                        MODE_FULL: begin
                            if (i_cls.dstall && i_cls.wstall) n_mode = MODE_DISARMED;
                            else if (i_cls.dstall)            n_mode = MODE_WEAPON;
                            else if (i_cls.wstall)            n_mode = MODE_DRIVE;
                        end
                        MODE_DRIVE: begin
                            if (i_cls.dstall) n_mode = MODE_DISARMED;
                        end
                        MODE_WEAPON: begin
                            if (i_cls.wstall) n_mode = MODE_DISARMED;
                        end
                        default: ;
                    endcase
                end
                CMD_LED: begin
                    if ((r_mode != r_shown) || r_first) begin
                        case (r_mode)
                            MODE_DISARMED: n_led = LED_OFF;
                            MODE_DRIVE:    n_led = LED_DRIVE;
                            MODE_FULL:     n_led = LED_FULL;
                            default: ;
                        endcase
                    end
                    if (r_mode == MODE_WEAPON) begin
                        n_led    = r_ripple;
                        n_ripple = {r_ripple[LED_W-2:0], r_ripple[LED_W-1]};
                    end
                    n_shown = r_mode;
                    n_first = 1'b0;
                end
                default: ;
            endcase
        end
    end

    a_ripple_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_ripple))
        else $error("ripple lost its single lit LED");

    a_failsafe_lowers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cls.cmd == CMD_FAILSAFE) |=> ((r_mode & ~$past(r_mode)) == 2'b00))
        else $error("failsafe raised the arming mode");

    a_weapon_ripple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cls.cmd == CMD_LED && r_mode == MODE_WEAPON) |=> $onehot(r_led))
        else $error("weapon-only tick did not show ripple");

endmodule

// ===== rtl/dual_channel_arming_controller.sv =====
// Top level of the dual channel arming controller.
//
// Arming interlock with four modes (disarmed, drive only, weapon only, fully
// armed) and four status LEDs. Every item returns one result: the mode and LED
// levels after that item. One item per clock cycle is sustained while
// m_axis_tready is held high, and each result is held until it is taken. The
// front end compares the channel levels against the configuration registers and
// pushes the classified item into a QUEUE_DEPTH entry queue; the back end pops
// one item a cycle, while its result register is free or being taken, into the
// arming state machine, whose registers form the result.
// Write configuration registers only while no item is in flight.
module dual_channel_arming_controller
    import dcac_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [LVL_W-1:0]       i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // weapon_switch_level, drive_switch_level, weapon_throttle, weapon_elevation,
    // weapon_rudder, weapon_aileron, weapon_lost, drive_lost, zero pad
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // cmd
    input  logic [IN_USER_W-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // arm_state, led_pattern, zero pad
    output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    t_cls             w_front_cls;
    t_cls             w_queue_cls;
    logic             w_full;
    logic             w_empty;
    logic             w_pop;
    logic             w_push;
    t_mode            w_mode;
    logic [LED_W-1:0] w_led;

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    dcac_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_data      (s_axis_tdata),
        .i_user      (s_axis_tuser),
        .o_cls       (w_front_cls)
    );

    dcac_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cls   (w_front_cls),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cls   (w_queue_cls)
    );

    dcac_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cls   (w_queue_cls),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_mode  (w_mode),
        .o_led   (w_led)
    );

    assign m_axis_tdata = {(OUT_DATA_W - LED_W - 2)'(0), w_led, w_mode};

endmodule
